// ----- rtl/stack_or_queue_store_defines.svh -----
// Assertion helpers for the stack or queue store.
// They sample on clk and are quiet while arst_n is low.
`ifndef STACK_OR_QUEUE_STORE_DEFINES_SVH
`define STACK_OR_QUEUE_STORE_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define SOQS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define SOQS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/soqs_pkg.sv -----
package soqs_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DATA_W = 32;

	// Register index on the configuration port, taken from paddr[2].
	localparam logic REG_DISCIPLINE = 1'b0;

	localparam logic DISC_STACK = 1'b0;
	localparam logic DISC_QUEUE = 1'b1;

	typedef enum logic [1:0] {
		MODE_PUSH  = 2'd0,
		MODE_POP   = 2'd1,
		MODE_DUMP  = 2'd2,
		MODE_CLEAR = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_EMPTY       = 2'd1,
		ST_FULL        = 2'd2,
		ST_CLEAR_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		mode_t                     mode;
		logic signed [DATA_W-1:0]  value;
		logic                      quiet;
	} soqs_in_t;

	typedef struct packed {
		status_t                   status;
		logic signed [DATA_W-1:0]  data_out;
		logic                      last;
	} soqs_out_t;

endpackage

// ----- rtl/soqs_mem.sv -----
module soqs_mem import soqs_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(DEPTH)-1:0]    waddr,
	input  logic signed [DATA_W-1:0]    wdata,
	input  logic                        re,
	input  logic [$clog2(DEPTH)-1:0]    raddr,
	output logic signed [DATA_W-1:0]    rdata
);

	logic signed [DATA_W-1:0] ram_q [DEPTH];

	// One write port and one registered read port; a read returns the
	// contents as they stood before a write at the same edge.
	always_ff @(posedge clk) begin
		if (we) begin
			ram_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= ram_q[raddr];
		end
	end

endmodule

// ----- rtl/stack_or_queue_store.sv -----
// Channel    Handshake              Payload
// -------    ---------              -------
// command    start in, busy out     cmd   (soqs_in_t: mode, value, quiet)
// result     rsp_valid out          rsp   (soqs_out_t: status, data_out, last)
// config     APB psel/penable       paddr, pwdata, prdata (discipline bit)
//
// A push leaves busy low, so pushes can come every cycle while the block is idle.
// A pop leaves busy low as well; its result appears in the cycle after the item.
// A dump or a loud clear of n entries holds busy high while it walks and
// gives one result per cycle, the first in the cycle after the item; the single
// memory read port sets this rate of one entry per cycle.
// Reset clears the pointers, the count and the discipline bit; the entry
// memory itself is not cleared, since only counted entries are ever read.
// The receiver cannot stall: every result is shown for exactly one cycle.

`include "stack_or_queue_store_defines.svh"

module stack_or_queue_store import soqs_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,

	input  logic         start,
	input  soqs_in_t     cmd,
	output logic         busy,

	output logic         rsp_valid,
	output soqs_out_t    rsp,

	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_CNT = CW'(1);

	// The block either takes items or walks the store for a dump or clear.
	typedef enum logic [1:0] {
		S_IDLE   = 2'b01,
		S_STREAM = 2'b10
	} state_t;

	state_t state_q, state_d;

	logic [AW-1:0] head_q, head_d;
	logic [AW-1:0] tail_q, tail_d;
	logic [CW-1:0] count_q, count_d;
	logic          disc_q;

	// Walk position and number of reads still to issue during a stream.
	logic [AW-1:0] idx_q, idx_d;
	logic [CW-1:0] left_q, left_d;

	// Result stage, aligned with the registered memory read data.
	logic          valid_s1;
	status_t       status_s1;
	logic          last_s1;

	logic          res_v;
	status_t       res_st;
	logic          res_last;

	logic          mem_we;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic signed [DATA_W-1:0] mem_rdata;

	logic          empty;
	logic          full;
	logic [AW-1:0] first_idx;

	function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] i);
		return (i == LAST_IDX) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] prev_idx(input logic [AW-1:0] i);
		return (i == '0) ? LAST_IDX : i - AW'(1);
	endfunction

	// One step in pop order: down from the top for a stack, up from the head
	// for a queue.
	function automatic logic [AW-1:0] step_idx(input logic [AW-1:0] i, input logic disc);
		return (disc == DISC_QUEUE) ? next_idx(i) : prev_idx(i);
	endfunction

	assign busy      = (state_q == S_STREAM);
	assign empty     = (count_q == '0);
	assign full      = (count_q == FULL_CNT);
	assign first_idx = (disc_q == DISC_QUEUE) ? head_q : prev_idx(tail_q);

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		idx_d     = idx_q;
		left_d    = left_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = first_idx;
		res_v     = 1'b0;
		res_st    = ST_OK;
		res_last  = 1'b1;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (cmd.mode)
						MODE_PUSH: begin
							if (full) begin
								res_v  = 1'b1;
								res_st = ST_FULL;
							end else begin
								mem_we  = 1'b1;
								tail_d  = next_idx(tail_q);
								count_d = count_q + ONE_CNT;
							end
						end
						MODE_POP: begin
							res_v = 1'b1;
							if (empty) begin
								res_st = ST_EMPTY;
							end else begin
								mem_re  = 1'b1;
								count_d = count_q - ONE_CNT;
								if (disc_q == DISC_QUEUE) begin
									head_d = next_idx(head_q);
								end else begin
									tail_d = first_idx;
								end
							end
						end
						MODE_DUMP, MODE_CLEAR: begin
							if (cmd.mode == MODE_CLEAR && cmd.quiet) begin
								head_d  = '0;
								tail_d  = '0;
								count_d = '0;
							end else if (empty) begin
								res_v  = 1'b1;
								res_st = (cmd.mode == MODE_CLEAR) ? ST_CLEAR_EMPTY : ST_EMPTY;
							end else begin
								// First entry is read now; the rest follow one a cycle.
								mem_re   = 1'b1;
								res_v    = 1'b1;
								res_last = (count_q == ONE_CNT);
								if (count_q != ONE_CNT) begin
									state_d = S_STREAM;
									idx_d   = step_idx(first_idx, disc_q);
									left_d  = count_q - ONE_CNT;
								end
								// A clear empties the store at once; the walk uses its own copy.
								if (cmd.mode == MODE_CLEAR) begin
									head_d  = '0;
									tail_d  = '0;
									count_d = '0;
								end
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_STREAM: begin
				mem_re    = 1'b1;
				mem_raddr = idx_q;
				res_v     = 1'b1;
				res_last  = (left_q == ONE_CNT);
				idx_d     = step_idx(idx_q, disc_q);
				left_d    = left_q - ONE_CNT;
				if (left_q == ONE_CNT) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	soqs_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (tail_q),
		.wdata (cmd.value),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			left_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			state_q  <= state_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			count_q  <= count_d;
			idx_q    <= idx_d;
			left_q   <= left_d;
			valid_s1 <= res_v;
		end
	end

	always_ff @(posedge clk) begin
		status_s1 <= res_st;
		last_s1   <= res_last;
	end

	// Configuration: one register, the discipline bit. The user must write it only
	// while the block is idle, so a walk never sees it change; the block does not enforce this.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_DISCIPLINE) ? {31'b0, disc_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disc_q <= DISC_STACK;
		end else if (psel && penable && pwrite && paddr[2] == REG_DISCIPLINE) begin
			disc_q <= pwdata[0];
		end
	end

	// Data is only meaningful with a good status; other results carry zero.
	assign rsp_valid = valid_s1;
	assign rsp = '{
		status:   status_s1,
		data_out: (status_s1 == ST_OK) ? mem_rdata : '0,
		last:     last_s1
	};

	`SOQS_ASSERT_SAME(a_count_bound, 1'b1, count_q <= FULL_CNT, "entry count above depth")
	`SOQS_ASSERT_NEXT(a_stream_emits, state_q == S_STREAM, rsp_valid, "walk cycle without result")
	`SOQS_ASSERT_SAME(a_nonlast_walks, rsp_valid && !rsp.last, state_q == S_STREAM, "result chain broken")
	`SOQS_ASSERT_NEXT(a_push_silent, start && !busy && cmd.mode == MODE_PUSH && !full, !rsp_valid, "push gave a result")

endmodule
